/* rtl/dao_pkg.sv */
// ----------------------------------------------------------------------------
// dao_pkg - shared types and constants for the Dadras attractor oscillator
// Sequencer states, register indexes, step op codes and saturation helper.
// ----------------------------------------------------------------------------
`default_nettype none

package dao_pkg;

    // Data word width (Q8.24 by default)
    localparam int DATA_W = 32;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_STEP,
        ST_POST,
        ST_INTERP,
        ST_EMIT
    } state_t;

    // Configuration register indexes
    typedef logic [2:0] reg_idx_t;
    localparam reg_idx_t REG_COEF_A    = 3'd0;
    localparam reg_idx_t REG_COEF_B    = 3'd1;
    localparam reg_idx_t REG_COEF_C    = 3'd2;
    localparam reg_idx_t REG_COEF_D    = 3'd3;
    localparam reg_idx_t REG_COEF_E    = 3'd4;
    localparam reg_idx_t REG_TIME_STEP = 3'd5;
    localparam reg_idx_t REG_STEPS     = 3'd6;
    localparam reg_idx_t REG_PERIOD    = 3'd7;

    // Euler step micro-ops, at most one product per op
    typedef logic [3:0] op_t;
    localparam op_t OP_AX   = 4'd0;   // a*x
    localparam op_t OP_BY   = 4'd1;   // b*y, save a*x
    localparam op_t OP_BYZ  = 4'd2;   // (b*y)*z
    localparam op_t OP_CY   = 4'd3;   // c*y, save b*y*z
    localparam op_t OP_XY   = 4'd4;   // x*y, save c*y
    localparam op_t OP_DX   = 4'd5;   // d*x, save x*y
    localparam op_t OP_DXY  = 4'd6;   // (d*x)*y
    localparam op_t OP_EZ   = 4'd7;   // e*z, save d*x*y
    localparam op_t OP_DERV = 4'd8;   // form the three derivatives
    localparam op_t OP_DTX  = 4'd9;   // dt*fx
    localparam op_t OP_DTY  = 4'd10;  // dt*fy, update x
    localparam op_t OP_DTZ  = 4'd11;  // dt*fz, update y
    localparam op_t OP_LAST = 4'd12;  // update z

    // Clamp a 36 bit signed sum to the 32 bit range
    function automatic logic signed [DATA_W-1:0] sat36(input logic signed [35:0] v);
        logic signed [35:0] hi;
        logic signed [35:0] lo;
        hi = 36'sh0_7FFF_FFFF;
        lo = -36'sh0_8000_0000;
        if (v > hi)
            return hi[DATA_W-1:0];
        else if (v < lo)
            return lo[DATA_W-1:0];
        else
            return v[DATA_W-1:0];
    endfunction

endpackage

`default_nettype wire

/* rtl/dao_fxmul.sv */
// ----------------------------------------------------------------------------
// dao_fxmul - shared fixed-point multiplier
// Signed 32x32 product, floor shift by the fraction width, saturate, register.
// ----------------------------------------------------------------------------
`default_nettype none

module dao_fxmul #(
    parameter int FRAC_BITS = 24
) (
    input  wire logic                            clk,
    input  wire logic signed [dao_pkg::DATA_W-1:0] op_a,
    input  wire logic signed [dao_pkg::DATA_W-1:0] op_b,
    output logic signed [dao_pkg::DATA_W-1:0]      prod_q
);

    logic signed [2*dao_pkg::DATA_W-1:0] full;
    logic signed [2*dao_pkg::DATA_W-1:0] shifted;
    logic signed [dao_pkg::DATA_W-1:0]   sat_val;
    logic signed [dao_pkg::DATA_W-1:0]   prod_reg;

    // arithmetic shift rounds toward minus infinity
    always_comb
    begin
        full    = 64'(op_a) * 64'(op_b);
        shifted = full >>> FRAC_BITS;
        if (shifted > 64'sh0000_0000_7FFF_FFFF)
            sat_val = 32'sh7FFF_FFFF;
        else if (shifted < -64'sh0000_0000_8000_0000)
            sat_val = 32'sh8000_0000;
        else
            sat_val = shifted[dao_pkg::DATA_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= sat_val;
    end

    assign prod_q = prod_reg;

endmodule

`default_nettype wire

/* rtl/dao_interp.sv */
// ----------------------------------------------------------------------------
// dao_interp - iterative linear interpolator
// from + (to - from) * ph / per, quotient toward zero, one quotient bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module dao_interp (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    input  wire logic signed [dao_pkg::DATA_W-1:0] from_val,
    input  wire logic signed [dao_pkg::DATA_W-1:0] to_val,
    input  wire logic [15:0]                       ph,
    input  wire logic [15:0]                       per,
    output logic                                   busy,
    output logic                                   done,
    output logic signed [dao_pkg::DATA_W-1:0]      result
);

    localparam int DVD_W = 49;
    localparam int CNT_W = 6;

    logic               busy_reg;
    logic               done_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [DVD_W-1:0]   dvd_reg;
    logic [16:0]        rem_reg;
    logic [15:0]        per_reg;
    logic               neg_reg;
    logic signed [31:0] from_reg;

    logic signed [32:0] diff;
    logic [32:0]        mag;
    logic [16:0]        trial;
    logic               fits;
    logic signed [35:0] sum;

    // magnitude of the difference and one division step
    always_comb
    begin
        diff  = 33'(to_val) - 33'(from_val);
        mag   = diff[32] ? 33'(-diff) : 33'(diff);
        trial = {rem_reg[15:0], dvd_reg[DVD_W-1]};
        fits  = trial >= {1'b0, per_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DVD_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // restoring divider datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg  <= DVD_W'(mag * 49'(ph));
            rem_reg  <= '0;
            per_reg  <= per;
            neg_reg  <= diff[32];
            from_reg <= from_val;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_reg <= trial - {1'b0, per_reg};
                dvd_reg <= {dvd_reg[DVD_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial;
                dvd_reg <= {dvd_reg[DVD_W-2:0], 1'b0};
            end
        end
    end

    // quotient stays below the difference magnitude
    always_comb
    begin
        if (neg_reg)
            sum = 36'(from_reg) - 36'({1'b0, dvd_reg[32:0]});
        else
            sum = 36'(from_reg) + 36'({1'b0, dvd_reg[32:0]});
    end

    assign busy   = busy_reg;
    assign done   = done_reg;
    assign result = dao_pkg::sat36(sum);

endmodule

`default_nettype wire

/* rtl/dadras_attractor_oscillator_unit.sv */
// ----------------------------------------------------------------------------
// dadras_attractor_oscillator_unit - Dadras attractor audio oscillator
// Euler integration of the Dadras system, one output item per input tick.
// ----------------------------------------------------------------------------
// Each accepted input item is one audio tick and yields one output item.
// A tick that updates runs 1 to 255 Euler steps; in mode 2 a tick without
// an update interpolates instead. The step time is set by the single shared
// 32x32 multiplier, which computes 11 products per step; the interpolation
// time by the bit-serial divider, one coordinate at a time. The input is not
// ready while a tick is being worked on. Configuration is written through
// cfg_we / cfg_index / cfg_data; the user must write it only while the block
// is idle, as the block itself does not enforce this.
`default_nettype none

module dadras_attractor_oscillator_unit #(
    parameter int OUTPUT_MODE = 2,
    parameter int FRAC_BITS   = 24
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [95:0] s_tdata,   // start_x, start_y, start_z
    input  wire logic        s_tuser,   // restart
    // output stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [95:0]      m_tdata,   // out_x, out_y, out_z
    // configuration
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    localparam bit MODE_PULSE  = (OUTPUT_MODE == 0);
    localparam bit MODE_HOLD   = (OUTPUT_MODE == 1);
    localparam bit MODE_INTERP = !MODE_PULSE && !MODE_HOLD;

    typedef logic signed [31:0] word_t;

    dao_pkg::state_t state_reg, state_next;

    // configuration registers
    word_t       coef_a_reg, coef_b_reg, coef_c_reg, coef_d_reg, coef_e_reg;
    word_t       time_step_reg;
    logic [7:0]  steps_reg;
    logic [15:0] period_reg;

    // point state
    word_t pos_x_reg, pos_y_reg, pos_z_reg;
    word_t prev_x_reg, prev_y_reg, prev_z_reg;
    word_t pend_x_reg, pend_y_reg, pend_z_reg;
    logic [15:0] phase_reg;

    // step temporaries
    word_t t_ax_reg, t_byz_reg, t_cy_reg, t_xy_reg, t_dxy_reg;
    word_t fx_reg, fy_reg, fz_reg;

    dao_pkg::op_t op_reg;
    logic [7:0]   step_cnt_reg;
    logic         upd_reg;
    logic [1:0]   coord_reg;

    // result and output register
    word_t res_x_reg, res_y_reg, res_z_reg;
    logic  m_valid_reg;
    logic [95:0] m_data_reg;

    logic  accept;
    logic  upd_now;
    logic  out_free;
    word_t mul_a, mul_b, mul_q;
    logic  ip_start, ip_busy, ip_done;
    logic [1:0] ip_sel;
    word_t ip_from, ip_to, ip_result;

    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign upd_now  = (phase_reg >= period_reg) ||
                      (MODE_INTERP && (phase_reg == 16'd0));

    // shared multiplier
    dao_fxmul #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mul (
        .clk    (clk),
        .op_a   (mul_a),
        .op_b   (mul_b),
        .prod_q (mul_q)
    );

    // operand select per step op
    always_comb
    begin
        case (op_reg)
            dao_pkg::OP_AX:  begin mul_a = coef_a_reg;    mul_b = pos_x_reg; end
            dao_pkg::OP_BY:  begin mul_a = coef_b_reg;    mul_b = pos_y_reg; end
            dao_pkg::OP_BYZ: begin mul_a = mul_q;         mul_b = pos_z_reg; end
            dao_pkg::OP_CY:  begin mul_a = coef_c_reg;    mul_b = pos_y_reg; end
            dao_pkg::OP_XY:  begin mul_a = pos_x_reg;     mul_b = pos_y_reg; end
            dao_pkg::OP_DX:  begin mul_a = coef_d_reg;    mul_b = pos_x_reg; end
            dao_pkg::OP_DXY: begin mul_a = mul_q;         mul_b = pos_y_reg; end
            dao_pkg::OP_EZ:  begin mul_a = coef_e_reg;    mul_b = pos_z_reg; end
            dao_pkg::OP_DTX: begin mul_a = time_step_reg; mul_b = fx_reg;    end
            dao_pkg::OP_DTY: begin mul_a = time_step_reg; mul_b = fy_reg;    end
            dao_pkg::OP_DTZ: begin mul_a = time_step_reg; mul_b = fz_reg;    end
            default:         begin mul_a = '0;            mul_b = '0;        end
        endcase
    end

    // interpolator, one coordinate at a time; operands of the coordinate
    // being started (x from the post state, the next one on each done)
    assign ip_sel = (state_reg == dao_pkg::ST_INTERP) ? (coord_reg + 2'd1) : 2'd0;

    always_comb
    begin
        case (ip_sel)
            2'd0:    begin ip_from = prev_x_reg; ip_to = pos_x_reg; end
            2'd1:    begin ip_from = prev_y_reg; ip_to = pos_y_reg; end
            default: begin ip_from = prev_z_reg; ip_to = pos_z_reg; end
        endcase
    end

    assign ip_start = MODE_INTERP &&
                      (((state_reg == dao_pkg::ST_POST) && (phase_reg != 16'd0)) ||
                       ((state_reg == dao_pkg::ST_INTERP) && ip_done &&
                        (coord_reg != 2'd2)));

    dao_interp u_interp (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ip_start),
        .from_val (ip_from),
        .to_val   (ip_to),
        .ph       (phase_reg),
        .per      (period_reg),
        .busy     (ip_busy),
        .done     (ip_done),
        .result   (ip_result)
    );

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= dao_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        s_tready   = 1'b0;
        unique case (state_reg)
            dao_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                    state_next = dao_pkg::ST_DECIDE;
            end
            dao_pkg::ST_DECIDE:
                state_next = upd_now ? dao_pkg::ST_STEP : dao_pkg::ST_POST;
            dao_pkg::ST_STEP:
                if ((op_reg == dao_pkg::OP_LAST) && (step_cnt_reg == 8'd1))
                    state_next = dao_pkg::ST_POST;
            dao_pkg::ST_POST:
                if (MODE_INTERP && (phase_reg != 16'd0))
                    state_next = dao_pkg::ST_INTERP;
                else
                    state_next = dao_pkg::ST_EMIT;
            dao_pkg::ST_INTERP:
                if (ip_done && (coord_reg == 2'd2))
                    state_next = dao_pkg::ST_EMIT;
            dao_pkg::ST_EMIT:
                if (out_free)
                    state_next = dao_pkg::ST_IDLE;
            default:
                state_next = dao_pkg::ST_IDLE;
        endcase
    end

    // datapath and control counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_a_reg    <= 32'sd50331648;
            coef_b_reg    <= 32'sd45298483;
            coef_c_reg    <= 32'sd28521267;
            coef_d_reg    <= 32'sd33554432;
            coef_e_reg    <= 32'sd150994944;
            time_step_reg <= 32'sd167772;
            steps_reg     <= 8'd1;
            period_reg    <= 16'd480;
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
            pos_z_reg     <= '0;
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            prev_z_reg    <= '0;
            pend_x_reg    <= '0;
            pend_y_reg    <= '0;
            pend_z_reg    <= '0;
            phase_reg     <= '0;
            op_reg        <= dao_pkg::OP_AX;
            step_cnt_reg  <= '0;
            upd_reg       <= 1'b0;
            coord_reg     <= '0;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            // configuration writes
            if (cfg_we)
            begin
                unique case (cfg_index)
                    dao_pkg::REG_COEF_A:    coef_a_reg    <= cfg_data;
                    dao_pkg::REG_COEF_B:    coef_b_reg    <= cfg_data;
                    dao_pkg::REG_COEF_C:    coef_c_reg    <= cfg_data;
                    dao_pkg::REG_COEF_D:    coef_d_reg    <= cfg_data;
                    dao_pkg::REG_COEF_E:    coef_e_reg    <= cfg_data;
                    dao_pkg::REG_TIME_STEP: time_step_reg <= cfg_data;
                    dao_pkg::REG_STEPS:     steps_reg     <= cfg_data[7:0];
                    dao_pkg::REG_PERIOD:    period_reg    <= cfg_data[15:0];
                    default:                ;
                endcase
            end

            if (m_valid_reg && m_tready && (state_reg != dao_pkg::ST_EMIT))
                m_valid_reg <= 1'b0;

            case (state_reg)
                // restart loads the start point
                dao_pkg::ST_IDLE:
                    if (accept && s_tuser)
                    begin
                        pos_x_reg  <= s_tdata[31:0];
                        pos_y_reg  <= s_tdata[63:32];
                        pos_z_reg  <= s_tdata[95:64];
                        prev_x_reg <= s_tdata[31:0];
                        prev_y_reg <= s_tdata[63:32];
                        prev_z_reg <= s_tdata[95:64];
                        pend_x_reg <= s_tdata[31:0];
                        pend_y_reg <= s_tdata[63:32];
                        pend_z_reg <= s_tdata[95:64];
                        phase_reg  <= '0;
                    end
                dao_pkg::ST_DECIDE:
                begin
                    upd_reg      <= upd_now;
                    op_reg       <= dao_pkg::OP_AX;
                    step_cnt_reg <= (steps_reg == 8'd0) ? 8'd1 : steps_reg;
                    if (MODE_INTERP && (phase_reg >= period_reg))
                    begin
                        prev_x_reg <= pos_x_reg;
                        prev_y_reg <= pos_y_reg;
                        prev_z_reg <= pos_z_reg;
                    end
                    if (MODE_PULSE)
                    begin
                        res_x_reg <= pend_x_reg;
                        res_y_reg <= pend_y_reg;
                        res_z_reg <= pend_z_reg;
                    end
                end
                // one Euler step, at most one product per cycle
                dao_pkg::ST_STEP:
                begin
                    case (op_reg)
                        dao_pkg::OP_BY:  t_ax_reg  <= mul_q;
                        dao_pkg::OP_CY:  t_byz_reg <= mul_q;
                        dao_pkg::OP_XY:  t_cy_reg  <= mul_q;
                        dao_pkg::OP_DX:  t_xy_reg  <= mul_q;
                        dao_pkg::OP_EZ:  t_dxy_reg <= mul_q;
                        dao_pkg::OP_DERV:
                        begin
                            fx_reg <= dao_pkg::sat36(36'(pos_y_reg) - 36'(t_ax_reg)
                                                     + 36'(t_byz_reg));
                            fy_reg <= dao_pkg::sat36(36'(t_cy_reg) - 36'(t_xy_reg)
                                                     + 36'(pos_z_reg));
                            fz_reg <= dao_pkg::sat36(36'(t_dxy_reg) - 36'(mul_q));
                        end
                        dao_pkg::OP_DTY:
                            pos_x_reg <= dao_pkg::sat36(36'(pos_x_reg) + 36'(mul_q));
                        dao_pkg::OP_DTZ:
                            pos_y_reg <= dao_pkg::sat36(36'(pos_y_reg) + 36'(mul_q));
                        dao_pkg::OP_LAST:
                            pos_z_reg <= dao_pkg::sat36(36'(pos_z_reg) + 36'(mul_q));
                        default:         ;
                    endcase
                    if (op_reg == dao_pkg::OP_LAST)
                    begin
                        op_reg       <= dao_pkg::OP_AX;
                        step_cnt_reg <= step_cnt_reg - 1'b1;
                        if (step_cnt_reg == 8'd1)
                            phase_reg <= '0;
                    end
                    else
                        op_reg <= op_reg + 1'b1;
                end
                // pick the output for this tick
                dao_pkg::ST_POST:
                begin
                    coord_reg <= '0;
                    if (MODE_PULSE)
                    begin
                        pend_x_reg <= upd_reg ? pos_x_reg : '0;
                        pend_y_reg <= upd_reg ? pos_y_reg : '0;
                        pend_z_reg <= upd_reg ? pos_z_reg : '0;
                    end
                    else if (MODE_HOLD)
                    begin
                        res_x_reg <= pos_x_reg;
                        res_y_reg <= pos_y_reg;
                        res_z_reg <= pos_z_reg;
                    end
                    else
                    begin
                        res_x_reg <= prev_x_reg;
                        res_y_reg <= prev_y_reg;
                        res_z_reg <= prev_z_reg;
                    end
                end
                dao_pkg::ST_INTERP:
                    if (ip_done)
                    begin
                        case (coord_reg)
                            2'd0:    res_x_reg <= ip_result;
                            2'd1:    res_y_reg <= ip_result;
                            default: res_z_reg <= ip_result;
                        endcase
                        coord_reg <= coord_reg + 1'b1;
                    end
                // hand the item to the output register
                dao_pkg::ST_EMIT:
                    if (out_free)
                    begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= {res_z_reg, res_y_reg, res_x_reg};
                        phase_reg   <= phase_reg + 1'b1;
                    end
                default: ;
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // checks
    a_step_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dao_pkg::ST_STEP) |-> (step_cnt_reg != 8'd0))
        else $error("step counter empty during Euler step");

    a_interp_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ip_busy |-> !s_tready)
        else $error("input ready while interpolating");

    a_phase_clear: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == dao_pkg::ST_STEP) && (op_reg == dao_pkg::OP_LAST) &&
         (step_cnt_reg == 8'd1)) |=> (phase_reg == 16'd0))
        else $error("phase not cleared after update");

endmodule

`default_nettype wire

/* dv/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb - Dadras attractor oscillator testbench
// Drives audio ticks with random restarts, predicts every output sample
// with a fixed-point Euler model and compares each field in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

    localparam int FRAC  = 24;
    localparam int WDOG  = 200000;

    // Oscillator predictor and expected-sample queue
    class osc_scoreboard;
        logic signed [31:0] cf [0:5];
        logic [7:0]  steps;
        logic [15:0] period;
        longint px, py, pz, qx, qy, qz;
        logic [15:0] phase;
        logic [95:0] want_q [$];
        int errors;

        function void init();
            cf[0] = 32'sd50331648;  cf[1] = 32'sd45298483; cf[2] = 32'sd28521267;
            cf[3] = 32'sd33554432;  cf[4] = 32'sd150994944; cf[5] = 32'sd167772;
            steps = 8'd1; period = 16'd480;
            px = 0; py = 0; pz = 0; qx = 0; qy = 0; qz = 0; phase = 0;
            errors = 0;
        endfunction

        function void set_reg(dao_pkg::reg_idx_t idx, logic [31:0] v);
            if (idx == dao_pkg::REG_STEPS) steps = v[7:0];
            else if (idx == dao_pkg::REG_PERIOD) period = v[15:0];
            else cf[idx] = v;
        endfunction

        function longint clamp(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        // floor shift then saturate
        function longint fmul(longint p, longint q);
            return clamp((p * q) >>> FRAC);
        endfunction

        function void euler();
            longint fx, fy, fz, a, b, c, d, e, dt;
            a = cf[0]; b = cf[1]; c = cf[2]; d = cf[3]; e = cf[4]; dt = cf[5];
            fx = clamp(py - fmul(a, px) + fmul(fmul(b, py), pz));
            fy = clamp(fmul(c, py) - fmul(px, py) + pz);
            fz = clamp(fmul(fmul(d, px), py) - fmul(e, pz));
            px = clamp(px + fmul(dt, fx));
            py = clamp(py + fmul(dt, fy));
            pz = clamp(pz + fmul(dt, fz));
        endfunction

        function longint lerp(longint from, longint to);
            if (phase == 0 || period == 0) return from;
            return clamp(from + ((to - from) * longint'(phase)) / longint'(period));
        endfunction

        // mode 2 tick
        function void note_tick(logic rs, logic [95:0] d);
            int n;
            logic [31:0] ox, oy, oz;
            if (rs) begin
                px = longint'($signed(d[31:0]));
                py = longint'($signed(d[63:32]));
                pz = longint'($signed(d[95:64]));
                qx = px; qy = py; qz = pz; phase = 0;
            end
            if (phase == 0 || phase >= period) begin
                if (phase >= period) begin
                    qx = px; qy = py; qz = pz;
                end
                n = (steps == 0) ? 1 : steps;
                for (int i = 0; i < n; i++) euler();
                phase = 0;
            end
            ox = lerp(qx, px); oy = lerp(qy, py); oz = lerp(qz, pz);
            want_q.push_back({oz, oy, ox});
            phase = phase + 16'd1;
        endfunction

        function void check_sample(logic [95:0] got);
            logic [95:0] w;
            if (want_q.size() == 0) begin
                $error("unexpected output item %h", got);
                errors++;
                return;
            end
            w = want_q.pop_front();
            if (w[31:0] !== got[31:0]) begin
                $error("out_x expected %h got %h", w[31:0], got[31:0]); errors++;
            end
            if (w[63:32] !== got[63:32]) begin
                $error("out_y expected %h got %h", w[63:32], got[63:32]); errors++;
            end
            if (w[95:64] !== got[95:64]) begin
                $error("out_z expected %h got %h", w[95:64], got[95:64]); errors++;
            end
        endfunction
    endclass

    logic        clk, rst_n;
    logic        s_tvalid, s_tready, s_tuser;
    logic [95:0] s_tdata;     // start_x, start_y, start_z
    logic        m_tvalid, m_tready;
    logic [95:0] m_tdata;     // out_x, out_y, out_z
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;

    osc_scoreboard sb;
    int  idle_cnt;
    bit  sink_on;

    dadras_attractor_oscillator_unit uut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Send one tick after a random gap
    task automatic send_tick(logic rs, logic [95:0] d);
        int gap;
        gap = $urandom_range(0, 16);
        if ($urandom_range(0, 3) == 0) gap = 0;
        repeat (gap) @(posedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= rs;
        s_tdata  <= d;
        do @(posedge clk); while (!s_tready);
        sb.note_tick(rs, d);
        s_tvalid <= 1'b0;
        // block stays busy after an accept
        @(posedge clk);
    endtask

    // Register writes only while no tick is in flight
    task automatic write_reg(dao_pkg::reg_idx_t idx, logic [31:0] v);
        while (sb.want_q.size() != 0) @(posedge clk);
        cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_reg(idx, v);
        @(posedge clk);
    endtask

    // Wait until every expected sample is out and the block has settled
    task automatic drain();
        while (sb.want_q.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom();
            default: return $signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000;
        endcase
    endfunction

    function automatic logic [95:0] rand_point();
        return {rand_coord(), rand_coord(), rand_coord()};
    endfunction

    // Output sink with random stalls
    always @(posedge clk)
    begin
        int stall;
        if (rst_n) begin
            if (m_tvalid && m_tready) begin
                sb.check_sample(m_tdata);
                stall = $urandom_range(0, 16);
                m_tready <= !(sink_on && stall > 0 && $urandom_range(0, 2) != 0);
            end else if (!m_tready) begin
                m_tready <= ($urandom_range(0, 3) == 0);
            end
        end
    end

    // Watchdog on accepted items
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            idle_cnt <= 0;
        else
            idle_cnt <= idle_cnt + 1;
        if (idle_cnt >= WDOG) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        sb = new();
        sb.init();
        idle_cnt = 0;
        sink_on = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0; s_tuser = 1'b0; s_tdata = '0;
        m_tready = 1'b1;
        cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset values, start points at extremes, short periods
        send_tick(1'b0, '0);
        send_tick(1'b1, {32'h0100_0000, 32'h0080_0000, 32'hFF00_0000});
        write_reg(dao_pkg::REG_PERIOD, 16'd4);
        for (int i = 0; i < 5; i++) send_tick(1'b0, ~96'd0);
        send_tick(1'b1, {3{32'h7FFF_FFFF}});
        send_tick(1'b0, '0);
        send_tick(1'b1, {3{32'h8000_0000}});
        send_tick(1'b0, '0);
        drain();
        // zero steps, zero period, extreme coefficients
        write_reg(dao_pkg::REG_STEPS, 8'd0);
        write_reg(dao_pkg::REG_PERIOD, 16'd0);
        write_reg(dao_pkg::REG_TIME_STEP, 32'h7FFF_FFFF);
        send_tick(1'b1, {32'h0100_0000, 32'h0100_0000, 32'h0100_0000});
        send_tick(1'b0, '0);
        write_reg(dao_pkg::REG_COEF_A, 32'h8000_0000);
        write_reg(dao_pkg::REG_COEF_B, 32'h7FFF_FFFF);
        write_reg(dao_pkg::REG_COEF_C, 32'h8000_0000);
        write_reg(dao_pkg::REG_COEF_D, 32'h7FFF_FFFF);
        write_reg(dao_pkg::REG_COEF_E, 32'h8000_0000);
        send_tick(1'b0, '0);
        send_tick(1'b1, {32'h0200_0000, 32'hFE00_0000, 32'h0300_0000});
        drain();
        // maximum step count, then a shortened period: phase already past the new value
        write_reg(dao_pkg::REG_PERIOD, 16'd10);
        write_reg(dao_pkg::REG_STEPS, 8'd255);
        for (int i = 0; i < 6; i++) send_tick(1'b0, '0);
        drain();
        write_reg(dao_pkg::REG_PERIOD, 16'd3);
        write_reg(dao_pkg::REG_STEPS, 8'd2);
        send_tick(1'b0, '0);
        send_tick(1'b0, '0);
        drain();
        write_reg(dao_pkg::REG_PERIOD, 16'hFFFF);
        send_tick(1'b0, '0);
        drain();

        // Random phases with varied settings
        sink_on = 1'b1;
        for (int ph = 0; ph < 8; ph++) begin
            write_reg(dao_pkg::REG_COEF_A,
                      ph == 0 ? 32'sd50331648 : $urandom_range(0, 32'h0600_0000));
            write_reg(dao_pkg::REG_COEF_B, $urandom_range(0, 32'h0400_0000));
            write_reg(dao_pkg::REG_COEF_C, $urandom_range(0, 32'h0300_0000));
            write_reg(dao_pkg::REG_COEF_D, $urandom_range(0, 32'h0300_0000));
            write_reg(dao_pkg::REG_COEF_E, $urandom_range(0, 32'h0A00_0000));
            write_reg(dao_pkg::REG_TIME_STEP,
                      (ph == 7) ? $urandom() : $urandom_range(0, 32'h0010_0000));
            write_reg(dao_pkg::REG_STEPS, (ph == 3) ? 8'd255 : $urandom_range(0, 8));
            write_reg(dao_pkg::REG_PERIOD, (ph == 5) ? 16'hFFFF : $urandom_range(0, 12));
            for (int i = 0; i < 34; i++)
                send_tick($urandom_range(0, 9) == 0, rand_point());
            drain();
        end

        drain();
        repeat (50) @(posedge clk);
        if (sb.errors == 0 && sb.want_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire
